// ===== rtl/drwc_pkg.sv =====
// Shared types, codes and constants of the display RAM window writer.
// Holds the controller/datapath command and status structs and the CRC-32 byte step.
// No dependencies.
`default_nettype none
package drwc_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] FUNC_SET_WIN  = 2'd0;
  localparam logic [1:0] FUNC_WR_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_WR_MONO  = 2'd2;
  localparam logic [1:0] FUNC_FRAME    = 2'd3;

  // visible row address range
  localparam logic [6:0] VIS_ROW_FIRST = 7'h0C;
  localparam logic [6:0] VIS_ROW_LAST  = 7'h4B;

  // reset values of cursor and window
  localparam logic [6:0] RST_COL_START = 7'h00;
  localparam logic [6:0] RST_COL_END   = 7'h3F;
  localparam logic [6:0] RST_ROW_START = 7'h0C;
  localparam logic [6:0] RST_ROW_END   = 7'h4B;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       invert;
    logic [6:0] col_first;
    logic [6:0] col_last;
    logic [6:0] row_first;
    logic [6:0] row_last;
  } drwc_item_t;

  typedef struct packed {
    logic       latch;     // capture the accepted item
    logic       set_win;   // load window bounds and cursor
    logic       put;       // one byte write at the cursor
    logic       mono;      // put takes a grey byte from the mono pattern
    logic [1:0] pair;      // mono pixel pair, most significant first
    logic       clr_step;  // write zero at the sweep address
    logic       crc_step;  // read the sweep address into the CRC
    logic       crc_fin;   // fold last byte, store CRC, count frame
    logic       load_out;  // load the result register
  } drwc_cmd_t;

  typedef struct packed {
    logic swp_last;        // sweep address is the last RAM entry
  } drwc_sts_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/display_ram_window_writer_crc.sv =====
// Top level of the display RAM window writer with frame CRC.
// Depends on drwc_pkg, drwc_ctrl and drwc_dp (which holds drwc_ram).
//
// A display RAM of COLUMNS x ROWS bytes is written through a window with an
// auto-advancing cursor; every input beat returns one result beat with the
// last frame CRC, the frame count and the cursor. After reset the block runs
// a clearing pass over all COLUMNS*ROWS entries, one RAM entry per cycle,
// with tready low. Then set window and write byte pass through EXEC and DONE,
// write mono makes one RAM write per grey byte, and frame complete reads the
// whole RAM through the single RAM read port that feeds the CRC one byte per
// cycle. The block is ready for the next beat as soon as a result enters the
// output register, whether or not that result has been taken yet.
`default_nettype none
module display_ram_window_writer_crc import drwc_pkg::*; #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 80
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // byte_value[7:0], invert[8], col_first[15:9], col_last[22:16],
  // row_first[29:23], row_last[36:30], zero fill [39:37]
  input  wire logic [39:0] s_axis_tdata_i,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // frame_crc[31:0], frame_count[63:32], cur_col[70:64], cur_row[77:71],
  // zero fill [79:78]
  output      logic [79:0] m_axis_tdata_o
);

  drwc_cmd_t   cmd;
  drwc_sts_t   sts;
  drwc_item_t  item;
  logic [31:0] frame_crc, frame_count;
  logic [6:0]  cur_col, cur_row;

  assign item.byte_value = s_axis_tdata_i[7:0];
  assign item.invert     = s_axis_tdata_i[8];
  assign item.col_first  = s_axis_tdata_i[15:9];
  assign item.col_last   = s_axis_tdata_i[22:16];
  assign item.row_first  = s_axis_tdata_i[29:23];
  assign item.row_last   = s_axis_tdata_i[36:30];

  drwc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .func_i    (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  drwc_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_crc_o   (frame_crc),
    .frame_count_o (frame_count),
    .cur_col_o     (cur_col),
    .cur_row_o     (cur_row)
  );

  assign m_axis_tdata_o = {2'b00, cur_row, cur_col, frame_count, frame_crc};

  // no beat is taken while the RAM or cursor is being worked on
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |->
      (!cmd.put && !cmd.clr_step && !cmd.crc_step && !cmd.crc_fin))
    else $error("beat accepted while the datapath is busy");

  // one beat at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second beat accepted while an item is in progress");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten before it was taken");

endmodule
`default_nettype wire

// ===== rtl/drwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module drwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 5120
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/drwc_ctrl.sv =====
// Controller of the display RAM window writer: sequences clear, writes and CRC sweep.
// Depends on drwc_pkg for the command and status structs and operation codes.
`default_nettype none
module drwc_ctrl import drwc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic [1:0] func_i,
  output      logic       s_ready_o,
  input  wire logic       m_ready_i,
  output      logic       m_valid_o,
  input  wire drwc_sts_t  sts_i,
  output      drwc_cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_CRC   = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] func_q, func_d;
  logic [1:0] k_q, k_d;
  logic       out_vld_q, out_vld_d;

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    k_d       = k_q;
    out_vld_d = out_vld_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;

    if (out_vld_q && m_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.swp_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          func_d      = func_i;
          k_d         = 2'd0;
          state_d     = (func_i == FUNC_FRAME) ? ST_CRC : ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (func_q)
          FUNC_SET_WIN: begin
            cmd_o.set_win = 1'b1;
            state_d       = ST_DONE;
          end
          FUNC_WR_BYTE: begin
            cmd_o.put = 1'b1;
            state_d   = ST_DONE;
          end
          FUNC_WR_MONO: begin
            cmd_o.put  = 1'b1;
            cmd_o.mono = 1'b1;
            cmd_o.pair = k_q;
            k_d        = k_q + 2'd1;
            if (k_q == 2'd3) begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.swp_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.crc_fin = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_vld_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      func_q    <= FUNC_SET_WIN;
      k_q       <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      func_q    <= func_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_valid_o = out_vld_q;

endmodule
`default_nettype wire

// ===== rtl/drwc_dp.sv =====
// Datapath of the display RAM window writer: cursor, window, RAM, CRC and result register.
// Depends on drwc_pkg and drwc_ram.
`default_nettype none
module drwc_dp import drwc_pkg::*; #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 80
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire drwc_item_t  item_i,
  input  wire drwc_cmd_t   cmd_i,
  output      drwc_sts_t   sts_o,
  output      logic [31:0] frame_crc_o,
  output      logic [31:0] frame_count_o,
  output      logic [6:0]  cur_col_o,
  output      logic [6:0]  cur_row_o
);

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  drwc_item_t  item_q;
  logic [6:0]  col_q, col_d, row_q, row_d;
  logic [6:0]  wcs_q, wcs_d, wce_q, wce_d, wrs_q, wrs_d, wre_q, wre_d;
  logic [31:0] crc_q, crc_d, frame_q, frame_d;
  logic [31:0] acc_q, acc_d;
  logic [AW-1:0] swp_q, swp_d;
  logic        rd_vld_q;
  logic        swp_last;

  logic        vis, in_store;
  logic [6:0]  row_off;
  logic [15:0] idx;
  logic [7:0]  pattern, put_val;
  logic [1:0]  pix;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign vis = (row_q >= VIS_ROW_FIRST) && (row_q <= VIS_ROW_LAST) &&
               ({1'b0, col_q} < 8'(COLUMNS));
  assign row_off  = row_q - VIS_ROW_FIRST;
  assign idx      = 16'(row_off) * 16'(COLUMNS) + 16'(col_q);
  assign in_store = idx < 16'(DEPTH);

  assign pattern = item_q.byte_value ^ {8{item_q.invert}};

  always_comb begin
    case (cmd_i.pair)
      2'd0:    pix = pattern[7:6];
      2'd1:    pix = pattern[5:4];
      2'd2:    pix = pattern[3:2];
      default: pix = pattern[1:0];
    endcase
  end

  // each pixel bit widens to one grey nibble
  assign put_val = cmd_i.mono ? {{4{pix[1]}}, {4{pix[0]}}} : item_q.byte_value;

  assign swp_last     = (swp_q == AW'(DEPTH - 1));
  assign sts_o.swp_last = swp_last;

  assign ram_we    = cmd_i.clr_step || (cmd_i.put && vis && in_store);
  assign ram_waddr = cmd_i.clr_step ? swp_q : idx[AW-1:0];
  assign ram_wdata = cmd_i.clr_step ? 8'd0 : put_val;

  drwc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (swp_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    wcs_d   = wcs_q;
    wce_d   = wce_q;
    wrs_d   = wrs_q;
    wre_d   = wre_q;
    crc_d   = crc_q;
    frame_d = frame_q;
    swp_d   = swp_q;
    acc_d   = acc_q;

    if (cmd_i.set_win) begin
      wce_d = item_q.col_last;
      wrs_d = item_q.row_first;
      wre_d = item_q.row_last;
      wcs_d = item_q.col_first;
      col_d = item_q.col_first;
      row_d = item_q.row_first;
    end

    // advance the cursor only on a visible write
    if (cmd_i.put && vis) begin
      if (col_q >= wce_q) begin
        col_d = wcs_q;
        row_d = (row_q >= wre_q) ? wrs_q : row_q + 7'd1;
      end else begin
        col_d = col_q + 7'd1;
      end
    end

    if (cmd_i.clr_step || cmd_i.crc_step) begin
      swp_d = swp_last ? '0 : swp_q + 1'b1;
    end

    if (cmd_i.latch) begin
      acc_d = CRC_INIT;
    end else if (rd_vld_q) begin
      acc_d = crc32_byte(acc_q, ram_rdata);
    end

    if (cmd_i.crc_fin) begin
      crc_d   = ~crc32_byte(acc_q, ram_rdata);
      frame_d = frame_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= RST_COL_START;
      row_q    <= RST_ROW_START;
      wcs_q    <= RST_COL_START;
      wce_q    <= RST_COL_END;
      wrs_q    <= RST_ROW_START;
      wre_q    <= RST_ROW_END;
      crc_q    <= 32'd0;
      frame_q  <= 32'd0;
      swp_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      wcs_q    <= wcs_d;
      wce_q    <= wce_d;
      wrs_q    <= wrs_d;
      wre_q    <= wre_d;
      crc_q    <= crc_d;
      frame_q  <= frame_d;
      swp_q    <= swp_d;
      rd_vld_q <= cmd_i.crc_step;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.load_out) begin
      frame_crc_o   <= crc_q;
      frame_count_o <= frame_q;
      cur_col_o     <= col_q;
      cur_row_o     <= row_q;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_display_ram_window_writer_crc.sv =====
// Self-checking testbench for display_ram_window_writer_crc: directed and random beats,
// every result beat compared against a cycle-free model of the RAM, cursor and frame CRC.
// Depends on drwc_pkg and the display_ram_window_writer_crc RTL.
`default_nettype none
module tb_display_ram_window_writer_crc;
  import drwc_pkg::*;

  localparam int COLS         = 64;
  localparam int ROWS_N       = 80;
  localparam int RAM_BYTES    = COLS * ROWS_N;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic [31:0] crc;
    logic [31:0] count;
    logic [6:0]  col;
    logic [6:0]  row;
  } disp_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = FUNC_SET_WIN;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned err_count       = 0;

  // model state
  logic [7:0]  ram_shadow [RAM_BYTES];
  logic [6:0]  cur_col    = RST_COL_START;
  logic [6:0]  cur_row    = RST_ROW_START;
  logic [6:0]  win_col_lo = RST_COL_START;
  logic [6:0]  win_col_hi = RST_COL_END;
  logic [6:0]  win_row_lo = RST_ROW_START;
  logic [6:0]  win_row_hi = RST_ROW_END;
  logic [31:0] frame_crc  = '0;
  logic [31:0] frame_cnt  = '0;

  disp_status_t exp_status_q[$];

  always #2 clk_i = ~clk_i;

  display_ram_window_writer_crc #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  // byte_value[7:0], invert[8], col_first[15:9], col_last[22:16],
  // row_first[29:23], row_last[36:30]
  function automatic logic [39:0] pack_beat(logic [7:0] b, logic inv, logic [6:0] cf,
                                            logic [6:0] cl, logic [6:0] rf, logic [6:0] rl);
    return {3'b000, rl, rf, cl, cf, inv, b};
  endfunction

  function automatic void put_pixel(logic [7:0] v);
    int unsigned idx;
    if (cur_row < VIS_ROW_FIRST || cur_row > VIS_ROW_LAST || cur_col > COLS - 1) begin
      return;
    end
    idx = (int'(cur_row) - int'(VIS_ROW_FIRST)) * COLS + int'(cur_col);
    if (idx < RAM_BYTES) begin
      ram_shadow[idx] = v;
    end
    // wrap uses >= so a start beyond the end wraps immediately
    if (cur_col >= win_col_hi) begin
      cur_col = win_col_lo;
      if (cur_row >= win_row_hi) begin
        cur_row = win_row_lo;
      end else begin
        cur_row = cur_row + 7'd1;
      end
    end else begin
      cur_col = cur_col + 7'd1;
    end
  endfunction

  function automatic logic [31:0] shadow_crc();
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < RAM_BYTES; i++) begin
      c = c ^ {24'd0, ram_shadow[i]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  function automatic disp_status_t predict_display_op(logic [1:0] func, logic [39:0] data);
    logic [7:0]   pattern;
    disp_status_t st;
    case (func)
      FUNC_SET_WIN: begin
        win_col_lo = data[15:9];
        win_col_hi = data[22:16];
        win_row_lo = data[29:23];
        win_row_hi = data[36:30];
        cur_col    = win_col_lo;
        cur_row    = win_row_lo;
      end
      FUNC_WR_BYTE: put_pixel(data[7:0]);
      FUNC_WR_MONO: begin
        pattern = data[8] ? ~data[7:0] : data[7:0];
        // most significant pixel pair first; each bit of a pair fills one nibble
        for (int k = 3; k >= 0; k--) begin
          put_pixel({{4{pattern[2*k+1]}}, {4{pattern[2*k]}}});
        end
      end
      FUNC_FRAME: begin
        frame_crc = shadow_crc();
        frame_cnt = frame_cnt + 32'd1;
      end
    endcase
    st.crc   = frame_crc;
    st.count = frame_cnt;
    st.col   = cur_col;
    st.row   = cur_row;
    return st;
  endfunction

  // Drive one beat, holding it until accepted; tvalid stays high for the next call.
  task automatic send_beat(logic [1:0] func, logic [39:0] data);
    @(negedge clk_i);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= func;
    do begin
      @(posedge clk_i);
    end while (s_axis_tready !== 1'b1);
    exp_status_q.push_back(predict_display_op(func, data));
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (exp_status_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : chk_result
    disp_status_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (exp_status_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_axis_tdata[31:0], '0);
      end else begin
        want = exp_status_q.pop_front();
        if (m_axis_tdata[31:0] !== want.crc) begin
          report_mismatch("frame_crc", m_axis_tdata[31:0], want.crc);
        end
        if (m_axis_tdata[63:32] !== want.count) begin
          report_mismatch("frame_count", m_axis_tdata[63:32], want.count);
        end
        if (m_axis_tdata[70:64] !== want.col) begin
          report_mismatch("cur_col", {25'd0, m_axis_tdata[70:64]}, {25'd0, want.col});
        end
        if (m_axis_tdata[77:71] !== want.row) begin
          report_mismatch("cur_row", {25'd0, m_axis_tdata[77:71]}, {25'd0, want.row});
        end
      end
    end
  end

  // CRC of the cleared RAM, then a write at the reset cursor
  task automatic test_reset_state();
    send_beat(FUNC_FRAME, pack_beat(8'h00, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_WR_BYTE, pack_beat(8'hFF, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
  endtask

  // bottom-right corner window: column wrap, row wrap, back to window start
  task automatic test_window_wrap();
    send_beat(FUNC_SET_WIN, pack_beat(8'h00, 1'b0, 7'd62, 7'd63, 7'd74, 7'd75));
    for (int i = 0; i < 5; i++) begin
      send_beat(FUNC_WR_BYTE, pack_beat(8'h11 * i[7:0], 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    end
  endtask

  // cursor outside the visible rows or columns: no store, no advance
  task automatic test_invisible_cursor();
    send_beat(FUNC_SET_WIN, pack_beat(8'h00, 1'b1, 7'd127, 7'd127, 7'd127, 7'd127));
    send_beat(FUNC_WR_BYTE, pack_beat(8'hA5, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_SET_WIN, pack_beat(8'h00, 1'b0, 7'd0, 7'd63, 7'd0, 7'd11));
    send_beat(FUNC_WR_BYTE, pack_beat(8'h5A, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_SET_WIN, pack_beat(8'h00, 1'b0, 7'd64, 7'd70, 7'd12, 7'd12));
    send_beat(FUNC_WR_MONO, pack_beat(8'hFF, 1'b1, 7'd0, 7'd0, 7'd0, 7'd0));
  endtask

  // start beyond end: every write wraps straight back to the start
  task automatic test_start_past_end();
    send_beat(FUNC_SET_WIN, pack_beat(8'h00, 1'b0, 7'd10, 7'd5, 7'd40, 7'd20));
    for (int i = 0; i < 3; i++) begin
      send_beat(FUNC_WR_BYTE, pack_beat(8'h3C + i[7:0], 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    end
  endtask

  task automatic test_mono_expansion();
    send_beat(FUNC_SET_WIN, pack_beat(8'h00, 1'b0, 7'd0, 7'd63, 7'd12, 7'd75));
    send_beat(FUNC_WR_MONO, pack_beat(8'h1B, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_WR_MONO, pack_beat(8'h1B, 1'b1, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_WR_MONO, pack_beat(8'h00, 1'b1, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_WR_MONO, pack_beat(8'hFF, 1'b0, 7'd0, 7'd0, 7'd0, 7'd0));
    send_beat(FUNC_FRAME, pack_beat(8'hFF, 1'b1, 7'd127, 7'd127, 7'd127, 7'd127));
  endtask

  // mostly windows inside the visible area, often narrow so the wraps come often
  function automatic logic [39:0] random_window();
    logic [6:0] cf, cl, rf, rl;
    if ($urandom_range(99, 0) < 75) begin
      cf = 7'($urandom_range(63, 0));
      cl = ($urandom_range(1, 0) == 0) ? 7'($urandom_range(63, cf))
                                       : ((cf > 55) ? 7'd63 : cf + 7'($urandom_range(7, 0)));
      rf = 7'($urandom_range(75, 12));
      rl = ($urandom_range(1, 0) == 0) ? 7'($urandom_range(75, rf))
                                       : ((rf > 70) ? 7'd75 : rf + 7'($urandom_range(4, 0)));
    end else begin
      cf = 7'($urandom_range(127, 0));
      cl = 7'($urandom_range(127, 0));
      rf = 7'($urandom_range(127, 0));
      rl = 7'($urandom_range(127, 0));
    end
    return pack_beat(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), cf, cl, rf, rl);
  endfunction

  function automatic logic [39:0] random_data();
    return pack_beat(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                     7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)),
                     7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
  endfunction

  task automatic test_random_traffic(int n_items);
    int unsigned pick;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        send_beat(FUNC_FRAME, random_data());
      end else if (pick < 12) begin
        send_beat(FUNC_SET_WIN, random_window());
      end else if (pick < 56) begin
        send_beat(FUNC_WR_BYTE, random_data());
      end else begin
        send_beat(FUNC_WR_MONO, random_data());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < RAM_BYTES; i++) begin
      ram_shadow[i] = 8'h00;
    end
    sender_idle_pct = 28;
    recv_idle_pct   = 76;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_window_wrap();
    test_invisible_cursor();
    test_start_past_end();
    test_mono_expansion();
    wait_all_results();

    test_random_traffic(160);
    wait_all_results();
    sender_idle_pct = 76;
    recv_idle_pct   = 28;
    test_random_traffic(160);
    wait_all_results();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    test_random_traffic(160);
    wait_all_results();

    // catch any stray result beat
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("display_ram_window_writer_crc regression: pass");
    end else begin
      $display("display_ram_window_writer_crc regression: fail");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("display_ram_window_writer_crc regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
